>>> rtl/core/windowed_slot_allocator_core_defines.svh
`ifndef WINDOWED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define WINDOWED_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define WSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wsa_pkg.sv
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants of the windowed slot allocator: request and
// status codes, the carry word that travels down the cell chain, the window
// broadcast and the map write port.
// ----------------------------------------------------------------------------
`default_nettype none

package wsa_pkg;

  localparam int WIN_W     = 7;                 // window and slot count width
  localparam int IDX_W     = 6;                 // slot_index / granted_slot width
  localparam int GROUP     = 8;                 // slots held by one cell
  localparam int MAX_SLOTS = (2 ** WIN_W) - 1;  // highest reachable slot count

  typedef logic [WIN_W-1:0] win_idx_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Word handed from cell to cell while a request sweeps the map
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic              found;   // free hole inside the window seen
    win_idx_t          slot;    // lowest such hole
    logic              hit;     // free target is a live slot
    logic              any;     // a slot stays valid after the free
    win_idx_t          first;   // first remaining valid slot
    win_idx_t          last;    // one past last remaining valid slot
  } carry_t;

  typedef struct packed {
    win_idx_t lo;
    win_idx_t hi;
    win_idx_t count;
  } window_t;

  typedef struct packed {
    logic     clear;
    logic     en;
    logic     set;
    win_idx_t slot;
  } map_wr_t;

endpackage

`default_nettype wire

>>> rtl/core/wsa_cell.sv
// ----------------------------------------------------------------------------
// wsa_cell
// One link of the allocator chain: holds the valid bits of a group of slots,
// folds them into the passing carry word and registers it for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wsa_cell import wsa_pkg::*; #(
  parameter int BASE  = 0,
  parameter int LANES = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire map_wr_t wr,
  input  wire window_t win,
  input  wire logic    cin_valid,
  input  wire carry_t  cin,
  output      logic    cout_valid,
  output      carry_t  cout
);

  logic [LANES-1:0] vbits;
  logic [LANES-1:0] free_w;
  logic [LANES-1:0] tgt;
  logic [LANES-1:0] post;
  carry_t           nxt;

  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      vbits <= '0;
    end else if (wr.en) begin
      for (int b = 0; b < LANES; b++) begin
        if (wr.slot == win_idx_t'(BASE + b)) begin
          vbits[b] <= wr.set;
        end
      end
    end
  end

  always_comb begin
    win_idx_t j;
    j = '0;
    for (int b = 0; b < LANES; b++) begin
      j         = win_idx_t'(BASE + b);
      free_w[b] = !vbits[b] && (j >= win.lo) && (j < win.hi);
      tgt[b]    = ({1'b0, cin.idx} == j) && (j < win.count);
      post[b]   = vbits[b] && !((cin.op == OP_FREE) && tgt[b]);
    end
  end

  always_comb begin
    nxt     = cin;
    nxt.hit = cin.hit || ((cin.op == OP_FREE) && |(tgt & vbits));
    // walk downwards so the lowest hole wins
    if (!cin.found) begin
      for (int b = LANES - 1; b >= 0; b--) begin
        if (free_w[b]) begin
          nxt.found = 1'b1;
          nxt.slot  = win_idx_t'(BASE + b);
        end
      end
    end
    if (!cin.any) begin
      for (int b = LANES - 1; b >= 0; b--) begin
        if (post[b]) begin
          nxt.first = win_idx_t'(BASE + b);
        end
      end
    end
    for (int b = 0; b < LANES; b++) begin
      if (post[b]) begin
        nxt.last = win_idx_t'(BASE + b + 1);
      end
    end
    if (|post) begin
      nxt.any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout_valid <= 1'b0;
    end else begin
      cout_valid <= cin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cin_valid) begin
      cout <= nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/windowed_slot_allocator_core.sv
// From acceptance, a request passes the cell registers in order, then its result is registered.
// Only one request is in flight: a new word is taken only after the last result commits; the request walks the
//   cell chain one cell of eight slots per cycle, then updates map and window.
// Reset (rst, synchronous): map and window cleared, slot count min(SLOTS,64), no result.
// ----------------------------------------------------------------------------
// windowed_slot_allocator_core
// Slot allocator over a valid map with a live window; allocate and free
// requests sweep a chain of map cells and commit at the end of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_slot_allocator_core import wsa_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [WIN_W-1:0] slot_count,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic             operation,
  input  wire logic [IDX_W-1:0] slot_index,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [1:0]       status,
  output      logic [IDX_W-1:0] granted_slot,
  output      logic [WIN_W-1:0] window_start,
  output      logic [WIN_W-1:0] window_end
);

  localparam int       CELLS       = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int       NCELL       = (CELLS + GROUP - 1) / GROUP;
  localparam win_idx_t CAP         = win_idx_t'(CELLS);
  localparam win_idx_t RESET_COUNT = win_idx_t'((SLOTS < 64) ? SLOTS : 64);

  logic       busy;
  logic       fin_valid;
  win_idx_t   lo;
  win_idx_t   hi;
  win_idx_t   slots_used;
  win_idx_t   lo_next;
  win_idx_t   hi_next;
  win_idx_t   cnt_next;
  win_idx_t   grant;
  status_t    res_status;
  logic       in_acc;
  logic       cfg_acc;
  logic       finish;
  map_wr_t    wr;
  window_t    win;
  carry_t     fin;

  logic [NCELL:0] link_valid;
  carry_t         link [NCELL+1];

  assign in_stall  = busy;
  assign cfg_ready = !busy;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign finish    = fin_valid && (!out_valid || !out_stall);

  assign win = '{lo: lo, hi: hi, count: slots_used};

  // launch word: request plus empty search results
  assign link_valid[0] = in_acc;
  always_comb begin
    link[0]       = '0;
    link[0].op    = op_t'(operation);
    link[0].idx   = slot_index;
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    localparam int BASE  = k * GROUP;
    localparam int LANES = ((CELLS - BASE) < GROUP) ? (CELLS - BASE) : GROUP;

    wsa_cell #(
      .BASE  (BASE),
      .LANES (LANES)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr         (wr),
      .win        (win),
      .cin_valid  (link_valid[k]),
      .cin        (link[k]),
      .cout_valid (link_valid[k+1]),
      .cout       (link[k+1])
    );
  end

  // last cell holds its word until the result is committed
  assign fin = link[NCELL];

  always_comb begin
    lo_next    = lo;
    hi_next    = hi;
    grant      = '0;
    res_status = ST_OK;
    wr         = '0;
    wr.clear   = cfg_acc;
    case (fin.op)
      OP_ALLOC: begin
        if (fin.found) begin
          grant = fin.slot;
        end else if (lo != '0) begin
          lo_next = lo - 1'b1;
          grant   = lo_next;
        end else if (hi < slots_used) begin
          grant   = hi;
          hi_next = hi + 1'b1;
        end else begin
          res_status = ST_FULL;
        end
        wr.en   = finish && (res_status == ST_OK);
        wr.set  = 1'b1;
        wr.slot = grant;
      end
      OP_FREE: begin
        if (fin.hit) begin
          lo_next = fin.any ? fin.first : '0;
          hi_next = fin.any ? fin.last : '0;
        end else begin
          res_status = ST_BAD;
        end
        wr.en   = finish && fin.hit;
        wr.set  = 1'b0;
        wr.slot = {1'b0, fin.idx};
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
  end

  // clamp the written slot count to [1, CAP]
  always_comb begin
    if (slot_count == '0) begin
      cnt_next = win_idx_t'(1);
    end else if (slot_count > CAP) begin
      cnt_next = CAP;
    end else begin
      cnt_next = slot_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo         <= '0;
      hi         <= '0;
      slots_used <= RESET_COUNT;
    end else if (cfg_acc) begin
      lo         <= '0;
      hi         <= '0;
      slots_used <= cnt_next;
    end else if (finish) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (link_valid[NCELL]) begin
        fin_valid <= 1'b1;
      end else if (finish) begin
        fin_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status       <= res_status;
      granted_slot <= grant[IDX_W-1:0];
      window_start <= lo_next;
      window_end   <= hi_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wsa_checker.sv
// ----------------------------------------------------------------------------
// wsa_checker
// Port-level checks on the allocator: result hold under stall, window
// ordering, grant on failure, and one request in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_slot_allocator_core_defines.svh"

module wsa_checker import wsa_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       status,
  input wire logic [IDX_W-1:0] granted_slot,
  input wire logic [WIN_W-1:0] window_start,
  input wire logic [WIN_W-1:0] window_end
);

  `WSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(granted_slot) && $stable(window_start) && $stable(window_end), "result word changed while stalled")

  `WSA_ASSERT_NOW(a_window_order, out_valid, window_start <= window_end, "window start beyond window end")

  `WSA_ASSERT_NOW(a_fail_no_grant, out_valid && (status != ST_OK), granted_slot == '0, "failed request carries a grant")

  `WSA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second word taken while a request is in flight")

endmodule

bind windowed_slot_allocator_core wsa_checker u_wsa_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: windowed slot allocator regression
// Drives allocate and free requests through the valid/stall channel. Each
// result word is checked field by field against an in-bench model of the
// valid map and its live window. The slot count register is rewritten
// between phases, with clamped and extreme values among them. Sender and
// receiver idle at changing rates, and one long receiver hold-off backs
// the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import wsa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS     = 64;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 200;
  localparam int SETTLE_LEN = 24;

  typedef struct {
    op_t              op;
    bit [IDX_W-1:0]   idx;
  } request_t;

  typedef struct {
    status_t          st;
    bit [IDX_W-1:0]   slot;
    bit [WIN_W-1:0]   ws;
    bit [WIN_W-1:0]   we;
  } grant_word_t;

  typedef struct {
    bit [NSLOTS-1:0]  map;
    bit [WIN_W-1:0]   lo;
    bit [WIN_W-1:0]   hi;
    bit [WIN_W-1:0]   count;
  } slot_pool_t;

  logic             clk;
  logic             rst          = 1'b1;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [WIN_W-1:0] cfg_count    = '0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic             operation    = 1'b0;
  logic [IDX_W-1:0] slot_index   = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [1:0]       status;
  logic [IDX_W-1:0] granted_slot;
  logic [WIN_W-1:0] window_start;
  logic [WIN_W-1:0] window_end;

  request_t     pending_req_q[$];
  grant_word_t  predicted_q[$];
  request_t     cur_req;
  slot_pool_t   dut_pool;
  slot_pool_t   gen_pool;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  bit           hold_req    = 1'b0;
  logic         rx_hold     = 1'b0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;

  windowed_slot_allocator_core #(.SLOTS(NSLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .slot_count   (cfg_count),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .window_start (window_start),
    .window_end   (window_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp the written count and clear the map and window
  function automatic void set_slot_count(inout slot_pool_t p, input bit [WIN_W-1:0] v);
    if (v == 0) begin
      p.count = WIN_W'(1);
    end else if (v > NSLOTS) begin
      p.count = WIN_W'(NSLOTS);
    end else begin
      p.count = v;
    end
    p.map = '0;
    p.lo  = '0;
    p.hi  = '0;
  endfunction

  function automatic void apply_request(inout slot_pool_t p, input request_t rq,
                                        output grant_word_t g);
    bit found;
    bit any;
    int grant;
    int first;
    int past;
    found = 1'b0;
    any   = 1'b0;
    grant = 0;
    first = 0;
    past  = 0;
    g.st  = ST_OK;
    if (rq.op == OP_ALLOC) begin
      // lowest hole inside the window, then grow downwards, then upwards
      for (int i = 0; i < NSLOTS; i++) begin
        if (!found && i >= p.lo && i < p.hi && !p.map[i]) begin
          grant = i;
          found = 1'b1;
        end
      end
      if (!found && p.lo > 0) begin
        p.lo  = p.lo - 1'b1;
        grant = int'(p.lo);
        found = 1'b1;
      end
      if (!found && p.hi < p.count) begin
        grant = int'(p.hi);
        p.hi  = p.hi + 1'b1;
        found = 1'b1;
      end
      if (found) begin
        p.map[grant[IDX_W-1:0]] = 1'b1;
      end else begin
        g.st  = ST_FULL;
        grant = 0;
      end
    end else begin
      if (rq.idx >= p.count || !p.map[rq.idx]) begin
        g.st = ST_BAD;
      end else begin
        p.map[rq.idx] = 1'b0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (i < p.count && p.map[i]) begin
            if (!any) first = i;
            any  = 1'b1;
            past = i + 1;
          end
        end
        p.lo = any ? first[WIN_W-1:0] : '0;
        p.hi = any ? past[WIN_W-1:0] : '0;
      end
    end
    g.slot = grant[IDX_W-1:0];
    g.ws   = p.lo;
    g.we   = p.hi;
  endfunction

  // Random live slot below the count, or -1 when the map is empty
  function automatic int pick_live(slot_pool_t p);
    int live[$];
    for (int i = 0; i < NSLOTS; i++) begin
      if (i < p.count && p.map[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  task automatic queue_req(input op_t op, input bit [IDX_W-1:0] idx);
    request_t rq;
    grant_word_t g;
    rq.op  = op;
    rq.idx = idx;
    apply_request(gen_pool, rq, g);
    pending_req_q.push_back(rq);
  endtask

  task automatic write_slot_count(input bit [WIN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_slot_count(dut_pool, v);
    gen_pool = dut_pool;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (pending_req_q.size() != 0 || in_valid || predicted_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Bursts of allocate-heavy and free-heavy traffic; most frees hit live slots
  task automatic gen_phase(input int n, input int fill);
    int burst;
    int pct;
    int live;
    op_t op;
    bit [IDX_W-1:0] idx;
    burst = 0;
    pct   = 50;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(8, 40);
        case ($urandom_range(2))
          0:       pct = 95;
          1:       pct = 60;
          default: pct = 25;
        endcase
      end
      burst--;
      op  = (k < fill || $urandom_range(99) < pct) ? OP_ALLOC : OP_FREE;
      idx = IDX_W'($urandom_range(63));
      if (op == OP_FREE && $urandom_range(99) < 80) begin
        live = pick_live(gen_pool);
        if (live >= 0) idx = live[IDX_W-1:0];
      end
      queue_req(op, idx);
    end
  endtask

  // Sender: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin : drive_req
    request_t nxt;
    grant_word_t g;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(dut_pool, cur_req, g);
        predicted_q.push_back(g);
      end
      if (!in_valid || !in_stall) begin
        if (pending_req_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_req_q.pop_front();
          cur_req    <= nxt;
          operation  <= nxt.op;
          slot_index <= nxt.idx;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_result
    grant_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: status=%0d slot=%0d window=[%0d,%0d)",
                     status, granted_slot, window_start, window_end);
        end else begin
          want = predicted_q.pop_front();
          if (status !== want.st || granted_slot !== want.slot ||
              window_start !== want.ws || window_end !== want.we) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected status=%0d slot=%0d window=[%0d,%0d)",
                       want.st, want.slot, want.ws, want.we,
                       " got status=%0d slot=%0d window=[%0d,%0d)",
                       status, granted_slot, window_start, window_end);
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("windowed_slot_allocator_core regression: fail");
      $finish;
    end
  end

  initial begin : run_test
    bit [WIN_W-1:0] cnt;
    int n;
    set_slot_count(dut_pool, WIN_W'(NSLOTS));
    gen_pool = dut_pool;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: window growth in both directions, holes, bad frees, empty map
    tx_idle_pct = 36;
    rx_idle_pct = 78;
    queue_req(OP_FREE,  6'd5);
    queue_req(OP_ALLOC, 6'd0);
    queue_req(OP_ALLOC, 6'd63);
    queue_req(OP_ALLOC, 6'd21);
    queue_req(OP_FREE,  6'd1);
    queue_req(OP_ALLOC, 6'd42);
    queue_req(OP_FREE,  6'd0);
    queue_req(OP_ALLOC, 6'd0);
    queue_req(OP_FREE,  6'd63);
    queue_req(OP_FREE,  6'd2);
    queue_req(OP_FREE,  6'd0);
    queue_req(OP_FREE,  6'd1);
    queue_req(OP_ALLOC, 6'd7);
    wait_drain();

    // Count of zero clamps to one: full map and out-of-range frees
    write_slot_count(7'd0);
    queue_req(OP_ALLOC, 6'd0);
    queue_req(OP_ALLOC, 6'd0);
    queue_req(OP_FREE,  6'd1);
    queue_req(OP_FREE,  6'd63);
    queue_req(OP_FREE,  6'd0);
    queue_req(OP_FREE,  6'd0);
    queue_req(OP_ALLOC, 6'd63);
    wait_drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin tx_idle_pct = 36; rx_idle_pct = 78; end
        1: begin tx_idle_pct = 78; rx_idle_pct = 36; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (ph)
        0:       cnt = 7'd127;
        1:       cnt = 7'd3;
        2:       cnt = 7'd64;
        4:       cnt = 7'd1;
        5:       cnt = 7'd64;
        6:       cnt = 7'd96;
        8:       cnt = 7'd64;
        9:       cnt = 7'd0;
        10:      cnt = 7'd2;
        default: cnt = WIN_W'($urandom_range(127));
      endcase
      write_slot_count(cnt);
      n = (dut_pool.count >= 32) ? 75 : 45;
      // fill to the top first in some phases so the full case is reached
      gen_phase(n, (ph == 0 || ph == 5 || ph == 8) ? dut_pool.count + 2 : 0);
      if (ph == 8) hold_req = 1'b1;
      wait_drain();
    end

    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatch_count == 0 && predicted_q.size() == 0) begin
      $display("windowed_slot_allocator_core regression: pass");
    end else begin
      $display("windowed_slot_allocator_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
